// ----- hdl/kts_pkg.sv -----
`timescale 1ns / 1ps

package kts_pkg;

    // Number of pose components stored with each keyframe.
    localparam int POSE_PARTS = 10;

    // Widths of the shared divider: the dividend carries a 33-bit time
    // difference shifted up by 16 bits, and the divisor a 33-bit span.
    localparam int DIV_DVD_W = 49;
    localparam int DIV_DVS_W = 33;

    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_PLAY   = 3'd1;
    localparam logic [2:0] KIND_PAUSE  = 3'd2;
    localparam logic [2:0] KIND_STOP   = 3'd3;
    localparam logic [2:0] KIND_LOAD   = 3'd4;
    localparam logic [2:0] KIND_SAMPLE = 3'd5;

    localparam logic [3:0] CFG_DURATION = 4'd0;
    localparam logic [3:0] CFG_SPEED    = 4'd1;
    localparam logic [3:0] CFG_LOOP     = 4'd2;
    localparam logic [3:0] CFG_COUNT    = 4'd3;

    localparam logic [15:0] SPEED_RESET = 16'd256;

    typedef struct packed {
        logic [2:0]         kind;
        logic [30:0]        delta_time;
        logic [5:0]         key_slot;
        logic [3:0]         key_part;
        logic signed [31:0] key_value;
    } in_item_t;

    typedef struct packed {
        logic               status;
        logic [30:0]        current_time;
        logic               is_running;
        logic [3:0]         part_index;
        logic signed [31:0] part_value;
        logic               last;
    } out_item_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_TICK_MUL,
        OP_TICK_ADD,
        OP_TICK_CLAMP,
        OP_MOD_START,
        OP_MOD_STORE,
        OP_PLAY,
        OP_PAUSE,
        OP_STOP,
        OP_LOAD,
        OP_RD_K0,
        OP_RD_KN,
        OP_HOLD_FIRST,
        OP_HOLD_LAST,
        OP_SCAN_START,
        OP_SCAN_NEXT,
        OP_ALPHA_START,
        OP_RD_PA,
        OP_RD_PB,
        OP_LERP_MUL,
        OP_EMIT_OK,
        OP_EMIT_ERR,
        OP_EMIT_PART
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TADD,
        ST_TSEL,
        ST_MOD,
        ST_CHK0,
        ST_CHKN,
        ST_SCAN,
        ST_DIV,
        ST_PA,
        ST_PB,
        ST_PM,
        ST_PE,
        ST_EMIT_OK,
        ST_EMIT_ERR
    } ctrl_state_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       speed_zero;
        logic       playing;
        logic       dur_zero;
        logic       loop_en;
        logic       count_zero;
        logic       t_le_rd;
        logic       t_ge_rd;
        logic       div_busy;
        logic       j_last;
        logic       out_free;
    } dp_status_t;

endpackage

// ----- hdl/kts_ram.sv -----
`timescale 1ns / 1ps

module kts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/kts_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module kts_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [kts_pkg::DIV_DVD_W-1:0]    dividend,
    input  logic [kts_pkg::DIV_DVS_W-1:0]    divisor,
    output logic                             busy,
    output logic [kts_pkg::DIV_DVD_W-1:0]    quotient,
    output logic [kts_pkg::DIV_DVS_W-1:0]    remainder
);

    import kts_pkg::*;

    localparam int CW = $clog2(DIV_DVD_W + 1);

    logic [CW-1:0]          cnt_reg;
    logic [DIV_DVD_W-1:0]   quo_reg;
    logic [DIV_DVS_W-1:0]   rem_reg;
    logic [DIV_DVS_W-1:0]   dvs_reg;
    logic [DIV_DVS_W:0]     shifted;
    logic [DIV_DVS_W+1:0]   diff;

    assign shifted = {rem_reg, quo_reg[DIV_DVD_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(DIV_DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            // The partial remainder stays below the divisor, so it fits.
            if (!diff[DIV_DVS_W+1])
            begin
                rem_reg <= diff[DIV_DVS_W-1:0];
            end
            else
            begin
                rem_reg <= shifted[DIV_DVS_W-1:0];
            end
            quo_reg <= {quo_reg[DIV_DVD_W-2:0], ~diff[DIV_DVS_W+1]};
        end
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- hdl/kts_dp.sv -----
`timescale 1ns / 1ps

module kts_dp #(
    parameter int MAX_KEYS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  kts_pkg::dp_op_t       op,
    output kts_pkg::dp_status_t   stat,
    input  kts_pkg::in_item_t     in_data,
    input  logic                  out_stall,
    output logic                  out_valid,
    output kts_pkg::out_item_t    out_data,
    input  logic                  cfg_valid,
    input  logic [3:0]            cfg_index,
    input  logic [30:0]           cfg_data
);

    import kts_pkg::*;

    localparam int KW = $clog2(MAX_KEYS);
    localparam int PW = $clog2(MAX_KEYS * POSE_PARTS);
    localparam int NW = $clog2(MAX_KEYS + 1);

    // Configuration and playback state.
    logic [30:0] dur_reg;
    logic [15:0] speed_reg;
    logic        loop_reg;
    logic [6:0]  count_reg;
    logic [30:0] time_reg;
    logic        playing_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;

    // Working registers of one item.
    in_item_t           item_reg;
    logic [46:0]        prod_reg;
    logic [39:0]        next_reg;
    logic [KW-1:0]      i_reg;
    logic [31:0]        prev_reg;
    logic [PW-1:0]      base_a_reg;
    logic [PW-1:0]      base_b_reg;
    logic [3:0]         j_reg;
    logic               interp_reg;
    logic [31:0]        va_reg;
    logic signed [50:0] lerp_reg;

    logic [NW-1:0]       n_sat;
    logic [KW-1:0]       n_m1;
    logic                slot_ok;
    logic                key_we;
    logic                pose_we;
    logic [PW-1:0]       pose_waddr;
    logic [KW-1:0]       key_raddr;
    logic [PW-1:0]       pose_raddr;
    logic [31:0]         key_rdata;
    logic [31:0]         pose_rdata;
    logic signed [33:0]  t_s;
    logic signed [33:0]  rd_s;
    logic signed [33:0]  prev_s;
    logic signed [33:0]  diff_t;
    logic signed [33:0]  span;
    logic signed [32:0]  d_pose;
    logic                out_free;
    logic                j_last;
    logic                div_start;
    logic [DIV_DVD_W-1:0] div_dvd;
    logic [DIV_DVS_W-1:0] div_dvs;
    logic                div_busy;
    logic [DIV_DVD_W-1:0] div_quo;
    logic [DIV_DVS_W-1:0] div_rem;

    assign n_sat   = (32'(count_reg) > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(count_reg);
    assign n_m1    = KW'(n_sat - 1'b1);
    assign slot_ok = (32'(item_reg.key_slot) < MAX_KEYS);
    assign key_we  = (op == OP_LOAD) && slot_ok && (item_reg.key_part == 4'd0);
    assign pose_we = (op == OP_LOAD) && slot_ok && (item_reg.key_part != 4'd0)
                     && (32'(item_reg.key_part) <= POSE_PARTS);
    assign pose_waddr = PW'(item_reg.key_slot) * PW'(POSE_PARTS)
                        + PW'(item_reg.key_part - 4'd1);

    always_comb
    begin
        case (op)
            OP_RD_K0:      key_raddr = '0;
            OP_RD_KN:      key_raddr = n_m1;
            OP_SCAN_START: key_raddr = KW'(1);
            OP_SCAN_NEXT:  key_raddr = i_reg + 1'b1;
            default:       key_raddr = i_reg;
        endcase
        case (op)
            OP_RD_PB: pose_raddr = base_b_reg + PW'(j_reg);
            default:  pose_raddr = base_a_reg + PW'(j_reg);
        endcase
    end

    kts_ram #(
        .WIDTH (32),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (KW'(item_reg.key_slot)),
        .wdata (item_reg.key_value),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    kts_ram #(
        .WIDTH (32),
        .DEPTH (MAX_KEYS * POSE_PARTS)
    ) u_pose_ram (
        .clk   (clk),
        .we    (pose_we),
        .waddr (pose_waddr),
        .wdata (item_reg.key_value),
        .raddr (pose_raddr),
        .rdata (pose_rdata)
    );

    assign t_s    = $signed({3'b000, time_reg});
    assign rd_s   = $signed({{2{key_rdata[31]}}, key_rdata});
    assign prev_s = $signed({{2{prev_reg[31]}}, prev_reg});
    assign diff_t = t_s - prev_s;
    assign span   = rd_s - prev_s;
    assign d_pose = $signed({pose_rdata[31], pose_rdata}) - $signed({va_reg[31], va_reg});

    assign div_start = (op == OP_MOD_START) || (op == OP_ALPHA_START);
    assign div_dvd   = (op == OP_MOD_START) ? DIV_DVD_W'(next_reg)
                                            : {diff_t[32:0], 16'd0};
    assign div_dvs   = (op == OP_MOD_START) ? DIV_DVS_W'(dur_reg) : span[32:0];

    kts_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign j_last   = (j_reg == 4'(POSE_PARTS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg       <= '0;
            speed_reg     <= SPEED_RESET;
            loop_reg      <= 1'b0;
            count_reg     <= '0;
            time_reg      <= '0;
            playing_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_DURATION: dur_reg   <= cfg_data;
                    CFG_SPEED:    speed_reg <= cfg_data[15:0];
                    CFG_LOOP:     loop_reg  <= cfg_data[0];
                    CFG_COUNT:    count_reg <= cfg_data[6:0];
                    default:      ;
                endcase
            end
            case (op)
                OP_PLAY:  playing_reg <= 1'b1;
                OP_PAUSE: playing_reg <= 1'b0;
                OP_STOP:
                begin
                    time_reg    <= '0;
                    playing_reg <= 1'b0;
                end
                OP_TICK_CLAMP:
                begin
                    if (next_reg >= 40'(dur_reg))
                    begin
                        time_reg    <= dur_reg;
                        playing_reg <= 1'b0;
                    end
                    else
                    begin
                        time_reg <= next_reg[30:0];
                    end
                end
                OP_MOD_STORE: time_reg <= div_rem[30:0];
                default:      ;
            endcase
            if (op == OP_EMIT_OK || op == OP_EMIT_ERR || op == OP_EMIT_PART)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_CAPTURE:  item_reg <= in_data;
            OP_TICK_MUL: prod_reg <= 47'(item_reg.delta_time) * 47'(speed_reg);
            OP_TICK_ADD: next_reg <= 40'(time_reg) + 40'(prod_reg[46:8]);
            OP_RD_KN:    prev_reg <= key_rdata;
            OP_HOLD_FIRST:
            begin
                base_a_reg <= '0;
                base_b_reg <= '0;
                interp_reg <= 1'b0;
                j_reg      <= '0;
            end
            OP_HOLD_LAST:
            begin
                base_a_reg <= PW'(n_m1) * PW'(POSE_PARTS);
                base_b_reg <= PW'(n_m1) * PW'(POSE_PARTS);
                interp_reg <= 1'b0;
                j_reg      <= '0;
            end
            OP_SCAN_START: i_reg <= KW'(1);
            OP_SCAN_NEXT:
            begin
                prev_reg <= key_rdata;
                i_reg    <= i_reg + 1'b1;
            end
            OP_ALPHA_START:
            begin
                base_a_reg <= PW'(i_reg - 1'b1) * PW'(POSE_PARTS);
                base_b_reg <= PW'(i_reg) * PW'(POSE_PARTS);
                interp_reg <= 1'b1;
                j_reg      <= '0;
            end
            OP_RD_PB:    va_reg <= pose_rdata;
            OP_LERP_MUL: lerp_reg <= 51'(d_pose) * 51'($signed({1'b0, div_quo[16:0]}));
            OP_EMIT_OK, OP_EMIT_ERR:
            begin
                out_reg.status       <= (op == OP_EMIT_ERR);
                out_reg.current_time <= time_reg;
                out_reg.is_running   <= playing_reg;
                out_reg.part_index   <= '0;
                out_reg.part_value   <= '0;
                out_reg.last         <= 1'b1;
            end
            OP_EMIT_PART:
            begin
                out_reg.status       <= 1'b0;
                out_reg.current_time <= time_reg;
                out_reg.is_running   <= playing_reg;
                out_reg.part_index   <= j_reg;
                out_reg.part_value   <= interp_reg ? $signed(va_reg + lerp_reg[47:16])
                                                   : $signed(va_reg);
                out_reg.last         <= j_last;
                j_reg                <= j_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assign stat.kind       = item_reg.kind;
    assign stat.speed_zero = (speed_reg == '0);
    assign stat.playing    = playing_reg;
    assign stat.dur_zero   = (dur_reg == '0);
    assign stat.loop_en    = loop_reg;
    assign stat.count_zero = (n_sat == '0);
    assign stat.t_le_rd    = (t_s <= rd_s);
    assign stat.t_ge_rd    = (t_s >= rd_s);
    assign stat.div_busy   = div_busy;
    assign stat.j_last     = j_last;
    assign stat.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- hdl/kts_ctrl.sv -----
`timescale 1ns / 1ps

module kts_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 idle,
    input  kts_pkg::dp_status_t  stat,
    output kts_pkg::dp_op_t      op
);

    import kts_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_CAPTURE;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.kind)
                    KIND_TICK:
                    begin
                        if (stat.speed_zero)
                        begin
                            state_next = ST_EMIT_ERR;
                        end
                        else if (!stat.playing)
                        begin
                            state_next = ST_EMIT_OK;
                        end
                        else if (stat.dur_zero)
                        begin
                            op         = OP_STOP;
                            state_next = ST_EMIT_OK;
                        end
                        else
                        begin
                            op         = OP_TICK_MUL;
                            state_next = ST_TADD;
                        end
                    end
                    KIND_PLAY:
                    begin
                        op         = OP_PLAY;
                        state_next = ST_EMIT_OK;
                    end
                    KIND_PAUSE:
                    begin
                        op         = OP_PAUSE;
                        state_next = ST_EMIT_OK;
                    end
                    KIND_STOP:
                    begin
                        op         = OP_STOP;
                        state_next = ST_EMIT_OK;
                    end
                    KIND_LOAD:
                    begin
                        op         = OP_LOAD;
                        state_next = ST_EMIT_OK;
                    end
                    KIND_SAMPLE:
                    begin
                        if (stat.count_zero)
                        begin
                            state_next = ST_EMIT_ERR;
                        end
                        else
                        begin
                            op         = OP_RD_K0;
                            state_next = ST_CHK0;
                        end
                    end
                    default: state_next = ST_EMIT_ERR;
                endcase
            end
            ST_TADD:
            begin
                op         = OP_TICK_ADD;
                state_next = ST_TSEL;
            end
            ST_TSEL:
            begin
                if (stat.loop_en)
                begin
                    op         = OP_MOD_START;
                    state_next = ST_MOD;
                end
                else
                begin
                    op         = OP_TICK_CLAMP;
                    state_next = ST_EMIT_OK;
                end
            end
            ST_MOD:
            begin
                if (!stat.div_busy)
                begin
                    op         = OP_MOD_STORE;
                    state_next = ST_EMIT_OK;
                end
            end
            ST_CHK0:
            begin
                if (stat.t_le_rd)
                begin
                    op         = OP_HOLD_FIRST;
                    state_next = ST_PA;
                end
                else
                begin
                    op         = OP_RD_KN;
                    state_next = ST_CHKN;
                end
            end
            ST_CHKN:
            begin
                if (stat.t_ge_rd)
                begin
                    op         = OP_HOLD_LAST;
                    state_next = ST_PA;
                end
                else
                begin
                    op         = OP_SCAN_START;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.t_le_rd)
                begin
                    op         = OP_ALPHA_START;
                    state_next = ST_DIV;
                end
                else
                begin
                    op = OP_SCAN_NEXT;
                end
            end
            ST_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_PA;
                end
            end
            ST_PA:
            begin
                op         = OP_RD_PA;
                state_next = ST_PB;
            end
            ST_PB:
            begin
                op         = OP_RD_PB;
                state_next = ST_PM;
            end
            ST_PM:
            begin
                op         = OP_LERP_MUL;
                state_next = ST_PE;
            end
            ST_PE:
            begin
                if (stat.out_free)
                begin
                    op         = OP_EMIT_PART;
                    state_next = stat.j_last ? ST_IDLE : ST_PA;
                end
            end
            ST_EMIT_OK:
            begin
                if (stat.out_free)
                begin
                    op         = OP_EMIT_OK;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_ERR:
            begin
                if (stat.out_free)
                begin
                    op         = OP_EMIT_ERR;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign idle = (state_reg == ST_IDLE);

endmodule

// ----- hdl/keyframe_timeline_sampler.sv -----
`timescale 1ns / 1ps

// Keyframe timeline sampler. The block holds a playback time and a playing
// flag, and a track of up to MAX_KEYS keyframes, each a Q16.16 time and ten
// Q16.16 pose components, which load transactions fill word by word. Tick,
// play, pause and stop transactions move the playback state and return one
// result; a sample transaction returns ten linearly interpolated components
// (position, scale, unnormalized quaternion) or one error result when the
// track is empty. One transaction is worked on at a time. A looping tick
// takes the wrap as a remainder from the one-bit-per-cycle divider. A
// sample finds its segment by a linear scan of the key time memory, then
// computes the weight in the same divider, then reads both keyframes' values
// for each component through the single read port of the pose memory; when
// the time lies outside the track the first or last keyframe is held and no
// weight is computed. A finished result waits in the output register while
// the next transaction is taken in. Stored keyframes have no reset value;
// sampling a keyframe that was never loaded returns unspecified values. The
// configuration port is always ready and is to be written while the block
// is idle.
module keyframe_timeline_sampler #(
    parameter int MAX_KEYS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  kts_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output kts_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_index,
    input  logic [30:0]         cfg_data
);

    import kts_pkg::*;

    dp_op_t     op;
    dp_status_t stat;
    logic       idle;

    // The controller sequences each transaction in its state register; the
    // datapath holds all other state, the two memories and the shared divider.
    kts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .idle     (idle),
        .stat     (stat),
        .op       (op)
    );

    kts_dp #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .stat      (stat),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    assign in_stall  = !idle;
    assign cfg_ready = 1'b1;

endmodule

// ----- hdl/kts_checker.sv -----
`timescale 1ns / 1ps

module kts_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input kts_pkg::out_item_t out_data
);

    // A result that is held back keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // Transactions are worked one at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction taken while busy");

    // An error result always stands alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> out_data.last && out_data.part_index == 4'd0)
        else $error("error result not a single result");

    // The tenth pose component always closes a multi-result sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> out_data.part_index != 4'd9)
        else $error("last component not marked last");

endmodule

bind keyframe_timeline_sampler kts_checker u_kts_checker (.*);
